/* rtl/iafd_pkg.sv */
// Package for the IMU angle frame decoder: frame positions, conversion constants
// and the frame item type passed from the byte receiver to the angle math pipeline.
// No dependencies.
`default_nettype none

package iafd_pkg;

    localparam logic [4:0] POS_FIRST_SUM = 5'd2;
    localparam logic [4:0] POS_LAST_SUM  = 5'd18;
    localparam logic [4:0] POS_X_FIRST   = 5'd7;
    localparam logic [4:0] POS_X_LAST    = 5'd10;
    localparam logic [4:0] POS_Y_FIRST   = 5'd11;
    localparam logic [4:0] POS_Y_LAST    = 5'd14;
    localparam logic [4:0] POS_Z_FIRST   = 5'd15;
    localparam logic [4:0] POS_Z_LAST    = 5'd18;
    localparam logic [4:0] POS_CHECK     = 5'd19;
    localparam logic [4:0] POS_LAST      = 5'd20;
    localparam logic [4:0] POS_IDLE      = 5'd21;

    localparam logic signed [31:0] Y_OFFSET   = 32'sd180000000;
    localparam logic signed [32:0] LEVEL_BIAS = 33'sd90000000;

    // Reciprocals for exact unsigned division of 32-bit values by constants
    localparam logic [31:0] RECIP_CENTI = 32'hD1B71759;  // /10000, shift 45
    localparam logic [31:0] RECIP_DEG   = 32'h431BDE83;  // /1000000, shift 50
    localparam logic [31:0] RECIP_200   = 32'h51EB851F;  // /200, shift 38

    localparam logic [15:0] DIVISOR_200 = 16'd200;
    localparam logic [15:0] SAT_POS_MAG = 16'd32767;
    localparam logic [15:0] SAT_NEG_MAG = 16'd32768;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] x;
        logic signed [31:0] y_adj;
        logic signed [31:0] z;
        logic signed [32:0] lv_raw;
    } t_frame_item;

endpackage

`default_nettype wire

/* rtl/imu_angle_frame_decoder.sv */
// Top level of the IMU angle frame decoder: byte receiver plus angle math pipeline.
// Depends on iafd_pkg, iafd_frame_rx and iafd_angle_math.
//
// Takes one frame byte per transfer, at up to one byte per clock, and after byte 20
// of a 21-byte frame delivers one result with the checksum flag and the converted
// angles; a mismatched frame gives frame_ok low and all other fields zero. A byte
// with frame_start restarts the frame; bytes while idle are dropped. The last byte's
// transfer loads the item register, and the result then passes the magnitude,
// reciprocal multiply, saturation, divide-by-200 multiply and output registers in
// turn. While results wait on the output side the block keeps taking bytes until
// six finished frames are held; then the input stalls.
`default_nettype none

module imu_angle_frame_decoder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [7:0]     i_byte_value,
    input  wire logic           i_frame_start,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_frame_ok,
    output logic signed [15:0]  o_x_centideg,
    output logic signed [15:0]  o_y_centideg,
    output logic signed [15:0]  o_z_centideg,
    output logic signed [15:0]  o_level_angle,
    output logic [7:0]          o_y_quot,
    output logic [7:0]          o_y_rem,
    output logic [7:0]          o_x_quot,
    output logic [7:0]          o_x_rem,
    output logic [7:0]          o_z_quot,
    output logic [7:0]          o_z_rem
);
    import iafd_pkg::*;

    logic        w_item_valid;
    logic        w_item_ready;
    t_frame_item w_item;

    iafd_frame_rx u_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_byte_value  (i_byte_value),
        .i_frame_start (i_frame_start),
        .o_item_valid  (w_item_valid),
        .o_item        (w_item),
        .i_item_ready  (w_item_ready)
    );

    iafd_angle_math u_math (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .o_item_ready  (w_item_ready),
        .i_item        (w_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_frame_ok    (o_frame_ok),
        .o_x_centideg  (o_x_centideg),
        .o_y_centideg  (o_y_centideg),
        .o_z_centideg  (o_z_centideg),
        .o_level_angle (o_level_angle),
        .o_y_quot      (o_y_quot),
        .o_y_rem       (o_y_rem),
        .o_x_quot      (o_x_quot),
        .o_x_rem       (o_x_rem),
        .o_z_quot      (o_z_quot),
        .o_z_rem       (o_z_rem)
    );

endmodule

`default_nettype wire

/* rtl/iafd_frame_rx.sv */
// Byte receiver: tracks frame position, Fletcher-style sums (modulo 256), angle capture
// and check byte, and emits one registered frame item after the last byte. Depends on iafd_pkg.
`default_nettype none

module iafd_frame_rx (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_byte_value,
    input  wire logic               i_frame_start,
    output logic                    o_item_valid,
    output iafd_pkg::t_frame_item   o_item,
    input  wire logic               i_item_ready
);
    import iafd_pkg::*;

    logic [4:0]  r_pos, n_pos;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [31:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic [31:0] r_z, n_z;
    logic [7:0]  r_check, n_check;
    logic        r_item_valid, n_item_valid;
    t_frame_item r_item, n_item;

    logic        w_accept;
    logic        w_active;
    logic [4:0]  w_pos;
    logic [7:0]  w_sum_a;
    logic [7:0]  w_sum_b;
    logic [1:0]  w_lane;

    assign o_in_ready   = !r_item_valid || i_item_ready;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_pos        = i_frame_start ? 5'd0 : r_pos;
    assign w_sum_a      = i_frame_start ? 8'd0 : r_sum_a;
    assign w_sum_b      = i_frame_start ? 8'd0 : r_sum_b;
    assign w_active     = (w_pos <= POS_LAST);
    assign w_lane       = w_pos[1:0] + 2'd1;
    assign o_item_valid = r_item_valid;
    assign o_item       = r_item;

    always_comb begin
        n_pos   = r_pos;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_check = r_check;
        if (w_accept && w_active) begin
            n_pos   = w_pos + 5'd1;
            n_sum_a = w_sum_a;
            n_sum_b = w_sum_b;
            if (w_pos >= POS_FIRST_SUM && w_pos <= POS_LAST_SUM) begin
                n_sum_a = w_sum_a + i_byte_value;
                n_sum_b = w_sum_b + n_sum_a;
            end
            if (w_pos >= POS_X_FIRST && w_pos <= POS_X_LAST) begin
                n_x[{w_lane, 3'b000} +: 8] = i_byte_value;
            end else if (w_pos >= POS_Y_FIRST && w_pos <= POS_Y_LAST) begin
                n_y[{w_lane, 3'b000} +: 8] = i_byte_value;
            end else if (w_pos >= POS_Z_FIRST && w_pos <= POS_Z_LAST) begin
                n_z[{w_lane, 3'b000} +: 8] = i_byte_value;
            end else if (w_pos == POS_CHECK) begin
                n_check = i_byte_value;
            end
        end
    end

    always_comb begin
        n_item_valid = r_item_valid;
        if (o_in_ready) begin
            n_item_valid = w_accept && (w_pos == POS_LAST);
        end
        n_item.ok     = (r_check == w_sum_a) && (i_byte_value == w_sum_b);
        n_item.x      = r_x;
        n_item.y_adj  = r_y[31] ? ($signed(r_y) + Y_OFFSET) : ($signed(r_y) - Y_OFFSET);
        n_item.z      = r_z;
        n_item.lv_raw = LEVEL_BIAS - $signed({r_x[31], r_x});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_IDLE;
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_z          <= '0;
            r_check      <= '0;
            r_item_valid <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_x          <= n_x;
            r_y          <= n_y;
            r_z          <= n_z;
            r_check      <= n_check;
            r_item_valid <= n_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/iafd_angle_math.sv */
// Angle conversion pipeline: magnitude, reciprocal multiply, saturation,
// division by 200 and the output register. Depends on iafd_pkg.
`default_nettype none

module iafd_angle_math (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_item_valid,
    output logic                        o_item_ready,
    input  wire iafd_pkg::t_frame_item  i_item,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_frame_ok,
    output logic signed [15:0]          o_x_centideg,
    output logic signed [15:0]          o_y_centideg,
    output logic signed [15:0]          o_z_centideg,
    output logic signed [15:0]          o_level_angle,
    output logic [7:0]                  o_y_quot,
    output logic [7:0]                  o_y_rem,
    output logic [7:0]                  o_x_quot,
    output logic [7:0]                  o_x_rem,
    output logic [7:0]                  o_z_quot,
    output logic [7:0]                  o_z_rem
);
    import iafd_pkg::*;

    localparam int NUM_STAGES = 5;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_rdy;

    logic signed [31:0] w_ang [3];
    logic signed [32:0] w_lv_abs;

    // stage B: magnitudes
    logic        r_b_ok;
    logic        r_b_neg [3];
    logic [31:0] r_b_mag [3];
    logic        r_b_lv_neg;
    logic [31:0] r_b_lv_mag;

    // stage C: reciprocal products
    logic [63:0] w_c_prod [3];
    logic [63:0] w_c_lv_prod;
    logic        r_c_ok;
    logic        r_c_neg [3];
    logic [18:0] r_c_q [3];
    logic        r_c_lv_neg;
    logic [13:0] r_c_lv_q;

    // stage D: saturation and sign
    logic [15:0] w_d_lim [3];
    logic [15:0] w_d_mag [3];
    logic        r_d_ok;
    logic        r_d_neg [3];
    logic [15:0] r_d_mag [3];
    logic [15:0] r_d_cent [3];
    logic [15:0] r_d_lv;

    // stage E: division by 200
    logic [47:0] w_e_prod [3];
    logic        r_e_ok;
    logic        r_e_neg [3];
    logic [15:0] r_e_mag [3];
    logic [15:0] r_e_cent [3];
    logic [7:0]  r_e_q [3];
    logic [15:0] r_e_lv;

    // output stage
    logic [15:0] w_rem16 [3];
    logic [7:0]  w_quot [3];
    logic [7:0]  w_rem [3];
    logic        r_o_ok;
    logic [15:0] r_o_cent [3];
    logic [15:0] r_o_lv;
    logic [7:0]  r_o_quot [3];
    logic [7:0]  r_o_rem [3];

    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_item_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_item_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_ang[0] = i_item.x;
    assign w_ang[1] = i_item.y_adj;
    assign w_ang[2] = i_item.z;
    assign w_lv_abs = i_item.lv_raw[32] ? -i_item.lv_raw : i_item.lv_raw;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c_prod[i] = 64'(r_b_mag[i]) * 64'(RECIP_CENTI);
            w_d_lim[i]  = r_c_neg[i] ? SAT_NEG_MAG : SAT_POS_MAG;
            w_d_mag[i]  = (r_c_q[i] > {3'b000, w_d_lim[i]}) ? w_d_lim[i] : r_c_q[i][15:0];
            w_e_prod[i] = 48'(r_d_mag[i]) * 48'(RECIP_200);
            w_rem16[i]  = r_e_mag[i] - 16'(r_e_q[i]) * DIVISOR_200;
            w_quot[i]   = r_e_neg[i] ? -r_e_q[i] : r_e_q[i];
            w_rem[i]    = r_e_neg[i] ? -w_rem16[i][7:0] : w_rem16[i][7:0];
        end
        w_c_lv_prod = 64'(r_b_lv_mag) * 64'(RECIP_DEG);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_b_ok     <= i_item.ok;
            for (int i = 0; i < 3; i++) begin
                r_b_neg[i] <= w_ang[i][31];
                r_b_mag[i] <= w_ang[i][31] ? 32'(-w_ang[i]) : 32'(w_ang[i]);
            end
            r_b_lv_neg <= i_item.lv_raw[32];
            r_b_lv_mag <= w_lv_abs[31:0];
        end
        if (w_rdy[1]) begin
            r_c_ok     <= r_b_ok;
            for (int i = 0; i < 3; i++) begin
                r_c_neg[i] <= r_b_neg[i];
                r_c_q[i]   <= w_c_prod[i][63:45];
            end
            r_c_lv_neg <= r_b_lv_neg;
            r_c_lv_q   <= w_c_lv_prod[63:50];
        end
        if (w_rdy[2]) begin
            r_d_ok <= r_c_ok;
            for (int i = 0; i < 3; i++) begin
                r_d_neg[i]  <= r_c_neg[i];
                r_d_mag[i]  <= w_d_mag[i];
                r_d_cent[i] <= r_c_neg[i] ? -w_d_mag[i] : w_d_mag[i];
            end
            r_d_lv <= r_c_lv_neg ? -{2'b00, r_c_lv_q} : {2'b00, r_c_lv_q};
        end
        if (w_rdy[3]) begin
            r_e_ok <= r_d_ok;
            for (int i = 0; i < 3; i++) begin
                r_e_neg[i]  <= r_d_neg[i];
                r_e_mag[i]  <= r_d_mag[i];
                r_e_cent[i] <= r_d_cent[i];
                r_e_q[i]    <= w_e_prod[i][45:38];
            end
            r_e_lv <= r_d_lv;
        end
        if (w_rdy[4]) begin
            r_o_ok <= r_e_ok;
            for (int i = 0; i < 3; i++) begin
                r_o_cent[i] <= r_e_ok ? r_e_cent[i] : 16'd0;
                r_o_quot[i] <= r_e_ok ? w_quot[i] : 8'd0;
                r_o_rem[i]  <= r_e_ok ? w_rem[i] : 8'd0;
            end
            r_o_lv <= r_e_ok ? r_e_lv : 16'd0;
        end
    end

    assign o_out_valid   = r_vld[NUM_STAGES-1];
    assign o_frame_ok    = r_o_ok;
    assign o_x_centideg  = $signed(r_o_cent[0]);
    assign o_y_centideg  = $signed(r_o_cent[1]);
    assign o_z_centideg  = $signed(r_o_cent[2]);
    assign o_level_angle = $signed(r_o_lv);
    assign o_x_quot      = r_o_quot[0];
    assign o_x_rem       = r_o_rem[0];
    assign o_y_quot      = r_o_quot[1];
    assign o_y_rem       = r_o_rem[1];
    assign o_z_quot      = r_o_quot[2];
    assign o_z_rem       = r_o_rem[2];

endmodule

`default_nettype wire

/* rtl/iafd_checker.sv */
// Port-level checker for the IMU angle frame decoder, bound to the top level.
// Depends on imu_angle_frame_decoder.
`default_nettype none

module iafd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_frame_ok,
    input wire logic [15:0] o_x_centideg,
    input wire logic [15:0] o_y_centideg,
    input wire logic [15:0] o_z_centideg,
    input wire logic [15:0] o_level_angle,
    input wire logic [7:0]  o_y_quot,
    input wire logic [7:0]  o_y_rem,
    input wire logic [7:0]  o_x_quot,
    input wire logic [7:0]  o_x_rem,
    input wire logic [7:0]  o_z_quot,
    input wire logic [7:0]  o_z_rem
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_x_centideg)
            && $stable(o_frame_ok) && $stable(o_y_quot) && $stable(o_z_rem))
        else $error("stalled result changed");

    a_bad_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_ok |-> o_x_centideg == 16'd0 && o_y_centideg == 16'd0
            && o_z_centideg == 16'd0 && o_level_angle == 16'd0 && o_x_quot == 8'd0
            && o_x_rem == 8'd0 && o_y_quot == 8'd0 && o_y_rem == 8'd0
            && o_z_quot == 8'd0 && o_z_rem == 8'd0)
        else $error("failed frame carries data");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_ok |-> $signed(o_level_angle) <= 16'sd2237
            && $signed(o_level_angle) >= -16'sd2057)
        else $error("level angle out of range");

endmodule

bind imu_angle_frame_decoder iafd_checker u_iafd_checker (.*);

`default_nettype wire
